[design/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked assertions, disabled while active-low reset is low, removable by ASSERT_OFF.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
`define ASSERT_AT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");
`define ASSERT_NEVER(lbl, clk, rst_n, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
    else $error("forbidden condition seen");
`else
`define ASSERT_AT(lbl, clk, rst_n, prop)
`define ASSERT_NEVER(lbl, clk, rst_n, expr)
`endif

`endif

[design/u16u8_pkg.sv]
// ----------------------------------------------------------------------------
// u16u8_pkg
// Shared types, constants and UTF-8 encoding helpers.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package u16u8_pkg;

  localparam logic [15:0] HI_SUR_MIN = 16'hD800;
  localparam logic [15:0] HI_SUR_MAX = 16'hDBFF;
  localparam logic [15:0] LO_SUR_MIN = 16'hDC00;
  localparam logic [15:0] LO_SUR_MAX = 16'hDFFF;
  localparam logic [20:0] SUPP_BASE  = 21'h10000;
  localparam logic [20:0] LIM_1B     = 21'h80;
  localparam logic [20:0] LIM_2B     = 21'h800;
  localparam logic [20:0] LIM_3B     = 21'h10000;

  typedef struct packed {
    logic        pre_valid;
    logic [15:0] pre_unit;
    logic        main_valid;
    logic [20:0] main_cp;
    logic        fin;
  } u16u8_job_t;

  function automatic logic is_high_sur(input logic [15:0] u);
    return (u >= HI_SUR_MIN) && (u <= HI_SUR_MAX);
  endfunction

  function automatic logic is_low_sur(input logic [15:0] u);
    return (u >= LO_SUR_MIN) && (u <= LO_SUR_MAX);
  endfunction

  // index of the last byte of the sequence (0..3)
  function automatic logic [1:0] cp_last_idx(input logic [20:0] cp);
    if (cp < LIM_1B) begin
      return 2'd0;
    end else if (cp < LIM_2B) begin
      return 2'd1;
    end else if (cp < LIM_3B) begin
      return 2'd2;
    end
    return 2'd3;
  endfunction

  function automatic logic [7:0] cp_byte(input logic [20:0] cp, input logic [1:0] last_idx,
                                         input logic [1:0] idx);
    logic [1:0] rem;
    logic [7:0] b;
    rem = last_idx - idx;
    if (idx == 2'd0) begin
      case (last_idx)
        2'd0:    b = {1'b0, cp[6:0]};
        2'd1:    b = {3'b110, cp[10:6]};
        2'd2:    b = {4'b1110, cp[15:12]};
        default: b = {5'b11110, cp[20:18]};
      endcase
    end else begin
      case (rem)
        2'd0:    b = {2'b10, cp[5:0]};
        2'd1:    b = {2'b10, cp[11:6]};
        default: b = {2'b10, cp[17:12]};
      endcase
    end
    return b;
  endfunction

endpackage

`default_nettype wire

[design/u16u8_fifo.sv]
// ----------------------------------------------------------------------------
// u16u8_fifo
// Two-entry job queue between classifier and byte encoder.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module u16u8_fifo (
  input  wire                   clk,
  input  wire                   rst_n,
  input  wire                   push,
  input  u16u8_pkg::u16u8_job_t wr_job,
  output logic                  full,
  input  wire                   pop,
  output logic                  rd_valid,
  output u16u8_pkg::u16u8_job_t rd_job
);
  import u16u8_pkg::*;

  u16u8_job_t mem_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;

  assign full     = (count_r == 2'd2);
  assign rd_valid = (count_r != 2'd0);
  assign rd_job   = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wr_job;
    end
  end

  `ASSERT_NEVER(a_no_overflow, clk, rst_n, push && full && !pop)
  `ASSERT_NEVER(a_no_underflow, clk, rst_n, pop && !rd_valid)
  `ASSERT_NEVER(a_count_range, clk, rst_n, count_r == 2'd3)

endmodule

`default_nettype wire

[design/u16u8_front.sv]
// ----------------------------------------------------------------------------
// u16u8_front
// Accepts code units, pairs surrogates and queues encode jobs.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module u16u8_front (
  input  wire                   clk,
  input  wire                   rst_n,
  input  wire                   in_valid,
  output logic                  in_ready,
  input  wire  [15:0]           in_code_unit,
  input  wire                   in_final_unit,
  input  wire                   q_full,
  output logic                  q_push,
  output u16u8_pkg::u16u8_job_t q_job
);
  import u16u8_pkg::*;

  logic        pend_r, pend_nxt;
  logic [15:0] pend_unit_r, pend_unit_nxt;
  logic        accept;
  logic        unit_hi, unit_lo;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;
  assign unit_hi  = is_high_sur(in_code_unit);
  assign unit_lo  = is_low_sur(in_code_unit);

  always_comb begin
    pend_nxt        = pend_r;
    pend_unit_nxt   = pend_unit_r;
    q_job.pre_valid = 1'b0;
    q_job.pre_unit  = pend_unit_r;
    q_job.main_valid = 1'b1;
    q_job.main_cp   = {5'd0, in_code_unit};
    q_job.fin       = in_final_unit;
    if (pend_r && unit_lo) begin
      q_job.main_cp = SUPP_BASE + {1'b0, pend_unit_r[9:0], in_code_unit[9:0]};
    end else begin
      q_job.pre_valid = pend_r;
      if (unit_hi && !in_final_unit) begin
        q_job.main_valid = 1'b0;
      end
    end
    if (accept) begin
      pend_nxt      = !(pend_r && unit_lo) && unit_hi && !in_final_unit;
      pend_unit_nxt = in_code_unit;
    end
    q_push = accept && (q_job.pre_valid || q_job.main_valid);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= 1'b0;
    end else begin
      pend_r <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pend_unit_r <= pend_unit_nxt;
  end

  `ASSERT_AT(a_hold_high, clk, rst_n, (accept && unit_hi && !in_final_unit) |=> pend_r)
  `ASSERT_AT(a_final_clears, clk, rst_n, (accept && in_final_unit) |=> !pend_r)

endmodule

`default_nettype wire

[design/u16u8_back.sv]
// ----------------------------------------------------------------------------
// u16u8_back
// Walks the queued job one UTF-8 byte per beat into the output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module u16u8_back (
  input  wire                   clk,
  input  wire                   rst_n,
  input  wire                   q_valid,
  input  u16u8_pkg::u16u8_job_t q_job,
  output logic                  q_pop,
  output logic                  out_valid,
  input  wire                   out_ready,
  output logic [7:0]            out_utf8_byte,
  output logic                  out_run_end,
  output logic                  out_string_end
);
  import u16u8_pkg::*;

  logic        phase_r, phase_nxt;
  logic [1:0]  idx_r, idx_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic [7:0]  byte_r;
  logic        run_end_r, str_end_r;
  logic        in_main, cp_done, job_done, fire;
  logic [20:0] cp;
  logic [1:0]  last_idx;

  always_comb begin
    in_main  = phase_r || !q_job.pre_valid;
    cp       = in_main ? q_job.main_cp : {5'd0, q_job.pre_unit};
    last_idx = cp_last_idx(cp);
    cp_done  = (idx_r == last_idx);
    job_done = cp_done && (in_main || !q_job.main_valid);
    fire     = q_valid && (!out_valid_r || out_ready);
    q_pop    = fire && job_done;

    phase_nxt     = phase_r;
    idx_nxt       = idx_r;
    out_valid_nxt = out_valid_r && !out_ready;
    if (fire) begin
      out_valid_nxt = 1'b1;
      if (job_done) begin
        phase_nxt = 1'b0;
        idx_nxt   = 2'd0;
      end else if (cp_done) begin
        phase_nxt = 1'b1;
        idx_nxt   = 2'd0;
      end else begin
        idx_nxt = idx_r + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= 1'b0;
      idx_r       <= 2'd0;
      out_valid_r <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      byte_r    <= cp_byte(cp, last_idx, idx_r);
      run_end_r <= job_done;
      str_end_r <= job_done && q_job.fin;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_utf8_byte  = byte_r;
  assign out_run_end    = run_end_r;
  assign out_string_end = str_end_r;

  `ASSERT_AT(a_str_end_on_run_end, clk, rst_n, (out_valid_r && str_end_r) |-> run_end_r)

endmodule

`default_nettype wire

[design/utf16le_to_utf8_transcoder.sv]
// Each input item's job is registered in the job queue; its bytes then go
// via the output register, one output byte per cycle while a job is queued
// and out_ready is high. Items give 1 to 6 bytes, a held high surrogate none.
// Input stalls only when the two-entry job queue is full.
// Reset (rst_n low, synchronous) drops any held surrogate, empties the queue
// and clears the output valid.
// ----------------------------------------------------------------------------
// utf16le_to_utf8_transcoder
// UTF-16 code units in, UTF-8 bytes out, surrogate pairs joined.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module utf16le_to_utf8_transcoder (
  input  wire        clk,
  input  wire        rst_n,
  input  wire        in_valid,
  output logic       in_ready,
  input  wire [15:0] in_code_unit,
  input  wire        in_final_unit,
  output logic       out_valid,
  input  wire        out_ready,
  output logic [7:0] out_utf8_byte,
  output logic       out_run_end,
  output logic       out_string_end
);
  import u16u8_pkg::*;

  u16u8_job_t push_job, head_job;
  logic       push, q_full, q_valid, pop;

  u16u8_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_code_unit  (in_code_unit),
    .in_final_unit (in_final_unit),
    .q_full        (q_full),
    .q_push        (push),
    .q_job         (push_job)
  );

  u16u8_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .wr_job   (push_job),
    .full     (q_full),
    .pop      (pop),
    .rd_valid (q_valid),
    .rd_job   (head_job)
  );

  u16u8_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_valid        (q_valid),
    .q_job          (head_job),
    .q_pop          (pop),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_utf8_byte  (out_utf8_byte),
    .out_run_end    (out_run_end),
    .out_string_end (out_string_end)
  );

endmodule

`default_nettype wire
